[rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and tables for the quaternion to Euler converter
// Holds the CORDIC arctangent table, pipeline depths and fixed widths.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES    = 30;
  localparam int NORM_RIGHT_CELLS = 7;
  localparam int NORM_LEFT_CELLS  = 5;
  localparam int VEC_LAT          = 1 + NORM_RIGHT_CELLS + NORM_LEFT_CELLS + CORDIC_STAGES;
  localparam int ISQRT_CELLS      = 31;
  localparam int ISQRT_W          = 61;
  localparam int ANGLE_W          = 32;
  localparam int NORM_W           = 32;
  localparam int CORDIC_W         = 33;
  localparam int NORM_EXP         = 30;

  function automatic logic [ANGLE_W-1:0] atan_turn(input int idx);
    logic [ANGLE_W-1:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic int right_shift(input int k);
    return (k < NORM_RIGHT_CELLS - 1) ? (32 >> k) : 1;
  endfunction

  function automatic int left_shift(input int k);
    return 16 >> k;
  endfunction

endpackage

[rtl/qte_stream_if.sv]
// ----------------------------------------------------------------------------
// qte_stream_if: valid/ready channels of the quaternion to Euler converter
// One interface carries quaternion items, the other carries angle items.
// ----------------------------------------------------------------------------
interface qte_quat_if import qte_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] roll_angle;
  logic signed [DATA_WIDTH-1:0] pitch_angle;
  logic signed [DATA_WIDTH-1:0] yaw_angle;

  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input yaw_angle, output ready);
endinterface

[rtl/qte_norm_cell.sv]
// ----------------------------------------------------------------------------
// qte_norm_cell: one conditional shift step of the vector normalizer
// Shifts a coordinate pair by a fixed amount when its magnitude calls for it.
// ----------------------------------------------------------------------------
module qte_norm_cell import qte_pkg::*; #(
  parameter int W            = 33,
  parameter int SHIFT        = 1,
  parameter bit LEFT         = 1'b0,
  parameter bit TEST_SHIFTED = 1'b1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out
);

  localparam int LIM_EXP = LEFT ? NORM_EXP - SHIFT : NORM_EXP;
  localparam logic signed [W-1:0] LIM = signed'(W'(64'd1 << LIM_EXP));

  logic signed [W-1:0] x_sh, y_sh, x_t, y_t;
  logic                take;
  logic signed [W-1:0] x_r, y_r;

  always_comb begin
    x_t = x_in;
    y_t = y_in;
    if (LEFT) begin
      x_sh = x_in <<< SHIFT;
      y_sh = y_in <<< SHIFT;
      take = (x_in < LIM) && (x_in > -LIM) && (y_in < LIM) && (y_in > -LIM);
    end else begin
      x_sh = x_in >>> SHIFT;
      y_sh = y_in >>> SHIFT;
      if (TEST_SHIFTED) begin
        x_t = x_sh;
        y_t = y_sh;
      end
      take = (x_t >= LIM) || (x_t <= -LIM) || (y_t >= LIM) || (y_t <= -LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= take ? x_sh : x_in;
      y_r <= take ? y_sh : y_in;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;

endmodule

[rtl/qte_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the pair toward the x axis and accumulates the binary angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell import qte_pkg::*; #(
  parameter int W     = CORDIC_W,
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic [ANGLE_W-1:0]  z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic [ANGLE_W-1:0]  z_out
);

  localparam logic [ANGLE_W-1:0] ATAN = atan_turn(STAGE);

  logic signed [W-1:0] dx, dy;
  logic signed [W-1:0] x_r, y_r;
  logic [ANGLE_W-1:0]  z_r;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[W-1]) begin
        x_r <= x_in + dx;
        y_r <= y_in - dy;
        z_r <= z_in + ATAN;
      end else begin
        x_r <= x_in - dx;
        y_r <= y_in + dy;
        z_r <= z_in - ATAN;
      end
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

[rtl/qte_isqrt_cell.sv]
// ----------------------------------------------------------------------------
// qte_isqrt_cell: one digit step of the integer square root
// Settles one result bit and carries a tag word along with the item.
// ----------------------------------------------------------------------------
module qte_isqrt_cell import qte_pkg::*; #(
  parameter int BIT_POS = 60,
  parameter int TAG_W   = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [ISQRT_W-1:0]       v_in,
  input  logic [ISQRT_W-1:0]       r_in,
  input  logic signed [TAG_W-1:0]  tag_in,
  output logic [ISQRT_W-1:0]       v_out,
  output logic [ISQRT_W-1:0]       r_out,
  output logic signed [TAG_W-1:0]  tag_out
);

  localparam logic [ISQRT_W-1:0] BIT_V = ISQRT_W'(64'd1 << BIT_POS);

  logic [ISQRT_W-1:0]      trial, v_nxt, r_nxt;
  logic [ISQRT_W-1:0]      v_r, r_r;
  logic signed [TAG_W-1:0] tag_r;

  always_comb begin
    trial = r_in + BIT_V;
    if (v_in >= trial) begin
      v_nxt = v_in - trial;
      r_nxt = (r_in >> 1) + BIT_V;
    end else begin
      v_nxt = v_in;
      r_nxt = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= v_nxt;
      r_r   <= r_nxt;
      tag_r <= tag_in;
    end
  end

  assign v_out   = v_r;
  assign r_out   = r_r;
  assign tag_out = tag_r;

endmodule

[rtl/qte_vector_unit.sv]
// ----------------------------------------------------------------------------
// qte_vector_unit: pipelined two-argument arctangent
// Half-plane fold, normalizer cells and a row of CORDIC cells.
// ----------------------------------------------------------------------------
module qte_vector_unit import qte_pkg::*; #(
  parameter int IN_W = 34
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] x_in,
  input  logic signed [IN_W-1:0] y_in,
  output logic [ANGLE_W-1:0]     z_out
);

  localparam int XW    = IN_W + 1;
  localparam int FLIPS = NORM_RIGHT_CELLS + NORM_LEFT_CELLS;
  localparam int NDLY  = FLIPS + CORDIC_STAGES;

  typedef struct packed {
    logic zero;
    logic flip;
  } vflag_t;

  vflag_t                flag_r [0:NDLY];
  logic signed [XW-1:0]  rx [0:NORM_RIGHT_CELLS];
  logic signed [XW-1:0]  ry [0:NORM_RIGHT_CELLS];
  logic signed [NORM_W-1:0] lx [0:NORM_LEFT_CELLS];
  logic signed [NORM_W-1:0] ly [0:NORM_LEFT_CELLS];
  logic signed [CORDIC_W-1:0] cx [0:CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] cy [0:CORDIC_STAGES];
  logic [ANGLE_W-1:0]    cz [0:CORDIC_STAGES];
  logic signed [XW-1:0]  x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in[IN_W-1]) begin
        x0_r <= -XW'(x_in);
        y0_r <= -XW'(y_in);
      end else begin
        x0_r <= XW'(x_in);
        y0_r <= XW'(y_in);
      end
      flag_r[0].zero <= (x_in == '0) && (y_in == '0);
      flag_r[0].flip <= x_in[IN_W-1];
      for (int k = 1; k <= NDLY; k++) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
  end

  assign rx[0] = x0_r;
  assign ry[0] = y0_r;

  for (genvar k = 0; k < NORM_RIGHT_CELLS; k++) begin : g_right
    qte_norm_cell #(
      .W            (XW),
      .SHIFT        (right_shift(k)),
      .LEFT         (1'b0),
      .TEST_SHIFTED (k < NORM_RIGHT_CELLS - 1)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (rx[k]),
      .y_in  (ry[k]),
      .x_out (rx[k+1]),
      .y_out (ry[k+1])
    );
  end

  assign lx[0] = rx[NORM_RIGHT_CELLS][NORM_W-1:0];
  assign ly[0] = ry[NORM_RIGHT_CELLS][NORM_W-1:0];

  for (genvar k = 0; k < NORM_LEFT_CELLS; k++) begin : g_left
    qte_norm_cell #(
      .W            (NORM_W),
      .SHIFT        (left_shift(k)),
      .LEFT         (1'b1),
      .TEST_SHIFTED (1'b0)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (lx[k]),
      .y_in  (ly[k]),
      .x_out (lx[k+1]),
      .y_out (ly[k+1])
    );
  end

  assign cx[0] = CORDIC_W'(lx[NORM_LEFT_CELLS]);
  assign cy[0] = CORDIC_W'(ly[NORM_LEFT_CELLS]);
  assign cz[0] = flag_r[FLIPS].flip ? 32'h80000000 : 32'h00000000;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qte_cordic_cell #(
      .W     (CORDIC_W),
      .STAGE (k)
    ) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[k]),
      .y_in  (cy[k]),
      .z_in  (cz[k]),
      .x_out (cx[k+1]),
      .y_out (cy[k+1]),
      .z_out (cz[k+1])
    );
  end

  assign z_out = flag_r[NDLY].zero ? '0 : cz[CORDIC_STAGES];

endmodule

[rtl/quaternion_to_euler_zyx_top.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx_top: unit quaternion to roll, pitch and yaw
// Fully pipelined converter built from rows of CORDIC and square-root cells.
// ----------------------------------------------------------------------------
// The in_ch channel takes one quaternion item (w, x, y, z, signed fixed point)
// per cycle unless the receiver stalls. The out_ch channel returns one item per
// quaternion with roll, pitch and yaw as signed binary angles, where the top
// code stands for pi. Throughput is one item per clock cycle while out_ch is
// not stalled. From acceptance to a valid result an item passes 2 product and
// sum stages, 3 pitch setup stages, 31 square-root cells and an arctangent unit
// (fold, 12 normalizer cells, 30 CORDIC cells), plus the output register.
// When the receiver stalls, the whole pipeline holds its items and an input
// skid register still takes one more item; in_ch.ready falls only while that
// register is occupied. Reset clears the valid bits and the skid valid flag;
// the data path needs no reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx_top import qte_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  qte_quat_if.sink   in_ch,
  qte_euler_if.source out_ch
);

  localparam int IN_FRAC   = (DATA_WIDTH - 1 > 30) ? 30 : DATA_WIDTH - 1;
  localparam int QW        = IN_FRAC + 1;
  localparam int PW        = 2 * QW;
  localparam int VW        = 2 * IN_FRAC + 4;
  localparam int VIN       = (VW > 32) ? VW : 32;
  localparam int PITCH_PRE = 3;
  localparam int RY_DLY    = PITCH_PRE + ISQRT_CELLS;
  localparam int CL_DLY    = PITCH_PRE - 1 + ISQRT_CELLS + VEC_LAT;
  localparam int TOTAL     = 2 + PITCH_PRE + ISQRT_CELLS + VEC_LAT + 1;
  localparam logic signed [VW-1:0] ONE = signed'(VW'(64'd1 << (2 * IN_FRAC)));
  localparam logic [ANGLE_W-1:0] HALF =
    (DATA_WIDTH < 32) ? ANGLE_W'(64'd1 << (31 - DATA_WIDTH)) : '0;

  logic en;
  logic take_in;
  logic s_valid;
  logic vld_r [1:TOTAL];

  logic                         skid_v_r;
  logic signed [DATA_WIDTH-1:0] sk_w_r, sk_x_r, sk_y_r, sk_z_r;
  logic signed [DATA_WIDTH-1:0] s_w, s_x, s_y, s_z;
  logic signed [QW-1:0]         qw, qx, qy, qz;

  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_zz_r;
  logic signed [PW-1:0] p_wy_r, p_zx_r, p_wz_r, p_xy_r;
  logic signed [VW-1:0] sr_r, cr_r, sp_r, sy_r, cy_r;

  logic signed [31:0]   s30_c, s30_r, s30b_r, s30c_r;
  logic [31:0]          s30_mag;
  logic [63:0]          s2_r;
  logic [ISQRT_W-1:0]   vrad_r;
  logic                 cl_pos_r [0:CL_DLY];
  logic                 cl_neg_r [0:CL_DLY];

  logic [ISQRT_W-1:0]   iv [0:ISQRT_CELLS];
  logic [ISQRT_W-1:0]   ir [0:ISQRT_CELLS];
  logic signed [31:0]   itag [0:ISQRT_CELLS];

  logic [ANGLE_W-1:0]   z_roll, z_yaw, z_pitch, z_pitch_sel;
  logic [ANGLE_W-1:0]   roll_d_r [1:RY_DLY];
  logic [ANGLE_W-1:0]   yaw_d_r  [1:RY_DLY];
  logic [ANGLE_W-1:0]   roll_sum, pitch_sum, yaw_sum;
  logic signed [DATA_WIDTH-1:0] roll_out_r, pitch_out_r, yaw_out_r;

  assign en           = !vld_r[TOTAL] || out_ch.ready;
  assign in_ch.ready  = !skid_v_r;
  assign take_in      = in_ch.valid && !skid_v_r;
  assign s_valid      = skid_v_r || in_ch.valid;
  assign s_w          = skid_v_r ? sk_w_r : in_ch.quat_w;
  assign s_x          = skid_v_r ? sk_x_r : in_ch.quat_x;
  assign s_y          = skid_v_r ? sk_y_r : in_ch.quat_y;
  assign s_z          = skid_v_r ? sk_z_r : in_ch.quat_z;
  assign qw           = $signed(s_w[DATA_WIDTH-1 -: QW]);
  assign qx           = $signed(s_x[DATA_WIDTH-1 -: QW]);
  assign qy           = $signed(s_y[DATA_WIDTH-1 -: QW]);
  assign qz           = $signed(s_z[DATA_WIDTH-1 -: QW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      for (int k = 1; k <= TOTAL; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (en) begin
        skid_v_r <= 1'b0;
        vld_r[1] <= s_valid;
        for (int k = 2; k <= TOTAL; k++) begin
          vld_r[k] <= vld_r[k-1];
        end
      end else if (take_in) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && take_in) begin
      sk_w_r <= in_ch.quat_w;
      sk_x_r <= in_ch.quat_x;
      sk_y_r <= in_ch.quat_y;
      sk_z_r <= in_ch.quat_z;
    end
  end

  // Products, product sums and the pitch argument setup.
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r <= PW'(qw) * PW'(qx);
      p_yz_r <= PW'(qy) * PW'(qz);
      p_xx_r <= PW'(qx) * PW'(qx);
      p_yy_r <= PW'(qy) * PW'(qy);
      p_zz_r <= PW'(qz) * PW'(qz);
      p_wy_r <= PW'(qw) * PW'(qy);
      p_zx_r <= PW'(qz) * PW'(qx);
      p_wz_r <= PW'(qw) * PW'(qz);
      p_xy_r <= PW'(qx) * PW'(qy);

      sr_r <= (VW'(p_wx_r) + VW'(p_yz_r)) <<< 1;
      cr_r <= ONE - ((VW'(p_xx_r) + VW'(p_yy_r)) <<< 1);
      sp_r <= (VW'(p_wy_r) - VW'(p_zx_r)) <<< 1;
      sy_r <= (VW'(p_wz_r) + VW'(p_xy_r)) <<< 1;
      cy_r <= ONE - ((VW'(p_yy_r) + VW'(p_zz_r)) <<< 1);

      s30_r       <= s30_c;
      cl_pos_r[0] <= sp_r >= ONE;
      cl_neg_r[0] <= sp_r <= -ONE;
      for (int k = 1; k <= CL_DLY; k++) begin
        cl_pos_r[k] <= cl_pos_r[k-1];
        cl_neg_r[k] <= cl_neg_r[k-1];
      end

      s2_r   <= 64'(s30_mag) * 64'(s30_mag);
      s30b_r <= s30_r;
      vrad_r <= ISQRT_W'((64'd1 << 60) - s2_r);
      s30c_r <= s30b_r;
    end
  end

  if (2 * IN_FRAC >= 30) begin : g_s30_down
    assign s30_c = 32'(sp_r >>> (2 * IN_FRAC - 30));
  end else begin : g_s30_up
    assign s30_c = 32'(sp_r) <<< (30 - 2 * IN_FRAC);
  end

  assign s30_mag = s30_r[31] ? 32'(-s30_r) : 32'(s30_r);

  assign iv[0]   = vrad_r;
  assign ir[0]   = '0;
  assign itag[0] = s30c_r;

  for (genvar k = 0; k < ISQRT_CELLS; k++) begin : g_isqrt
    qte_isqrt_cell #(
      .BIT_POS (60 - 2 * k),
      .TAG_W   (32)
    ) u_cell (
      .clk     (clk),
      .en      (en),
      .v_in    (iv[k]),
      .r_in    (ir[k]),
      .tag_in  (itag[k]),
      .v_out   (iv[k+1]),
      .r_out   (ir[k+1]),
      .tag_out (itag[k+1])
    );
  end

  qte_vector_unit #(.IN_W(VIN)) u_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (VIN'(cr_r)),
    .y_in  (VIN'(sr_r)),
    .z_out (z_roll)
  );

  qte_vector_unit #(.IN_W(VIN)) u_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (VIN'(cy_r)),
    .y_in  (VIN'(sy_r)),
    .z_out (z_yaw)
  );

  qte_vector_unit #(.IN_W(VIN)) u_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  (signed'(VIN'(ir[ISQRT_CELLS][30:0]))),
    .y_in  (VIN'(itag[ISQRT_CELLS])),
    .z_out (z_pitch)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      roll_d_r[1] <= z_roll;
      yaw_d_r[1]  <= z_yaw;
      for (int k = 2; k <= RY_DLY; k++) begin
        roll_d_r[k] <= roll_d_r[k-1];
        yaw_d_r[k]  <= yaw_d_r[k-1];
      end
    end
  end

  always_comb begin
    if (cl_pos_r[CL_DLY]) begin
      z_pitch_sel = 32'h40000000;
    end else if (cl_neg_r[CL_DLY]) begin
      z_pitch_sel = 32'hC0000000;
    end else begin
      z_pitch_sel = z_pitch;
    end
  end

  assign roll_sum  = roll_d_r[RY_DLY] + HALF;
  assign pitch_sum = z_pitch_sel + HALF;
  assign yaw_sum   = yaw_d_r[RY_DLY] + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      roll_out_r  <= $signed(roll_sum[ANGLE_W-1 -: DATA_WIDTH]);
      pitch_out_r <= $signed(pitch_sum[ANGLE_W-1 -: DATA_WIDTH]);
      yaw_out_r   <= $signed(yaw_sum[ANGLE_W-1 -: DATA_WIDTH]);
    end
  end

  assign out_ch.valid       = vld_r[TOTAL];
  assign out_ch.roll_angle  = roll_out_r;
  assign out_ch.pitch_angle = pitch_out_r;
  assign out_ch.yaw_angle   = yaw_out_r;

`ifndef SYNTH
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && en) |=> !skid_v_r)
    else $error("Skid item was not moved into the pipeline when it advanced.");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !en) |=> skid_v_r)
    else $error("Item accepted during a stall was not held in the skid register.");
`endif

endmodule
